>>> hw/rtl/llm_pkg.sv
package llm_pkg;

    localparam int PatBytes = 32;
    localparam int WordBits = 64;
    localparam int NumWords = 4;
    localparam int AddrBits = 6;

    localparam logic [7:0] CharNl  = 8'h0A;
    localparam logic [7:0] CharUpA = 8'h41;
    localparam logic [7:0] CharUpZ = 8'h5A;
    localparam logic [7:0] CharLoA = 8'h61;

    localparam logic [2:0] RegPat0       = 3'd0;
    localparam logic [2:0] RegPat1       = 3'd1;
    localparam logic [2:0] RegPat2       = 3'd2;
    localparam logic [2:0] RegPat3       = 3'd3;
    localparam logic [2:0] RegPatLen     = 3'd4;
    localparam logic [2:0] RegIgnoreCase = 3'd5;
    localparam logic [2:0] RegInvert     = 3'd6;
    localparam logic [2:0] RegCountOnly  = 3'd7;

    localparam logic KindLine    = 1'b0;
    localparam logic KindSummary = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } t_in_beat;

    typedef struct packed {
        logic        result_kind;
        logic [31:0] line_number;
        logic        selected;
        logic [31:0] selected_count;
        logic        any_selected;
        logic        last;
    } t_out_beat;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_win_ctl;

    function automatic logic [7:0] fold(input logic [7:0] c, input logic en);
        logic [7:0] r;
        r = c;
        if (en && c >= CharUpA && c <= CharUpZ) begin
            r = c - CharUpA + CharLoA;
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/literal_line_matcher.sv
// channel  | dir | handshake                   | beat
// ---------+-----+-----------------------------+-----------
// input    | in  | i_in_valid / o_in_ready     | t_in_beat
// output   | out | o_out_valid / i_out_ready   | t_out_beat
// config   | in  | APB psel/penable/pwrite     | 64-bit reg
//
// One byte per cycle unless the output stalls. A beat is registered, then tested
// against the window once the queue has room; its results land in a two-entry
// output queue. An end-of-stream beat that closes an open line yields a verdict and
// a summary beat, only the summary in count-only mode. Output stalls back up
// through the queue into o_in_ready. Synchronous active-low reset clears config,
// counters and line state.
module literal_line_matcher
    import llm_pkg::*;
#(
    parameter int MAX_PATTERN = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [AddrBits-1:0] paddr,
    input  logic [WordBits-1:0] pwdata,
    output logic [WordBits-1:0] prdata,
    output logic                pready,

    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  t_in_beat            i_in_beat,

    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_out_beat           o_out_beat
);

    localparam logic [31:0] Sat32 = 32'hFFFF_FFFF;

    logic [NumWords-1:0][WordBits-1:0] r_pat;
    logic [5:0]                        r_pat_len;
    logic                              r_ignore_case;
    logic                              r_invert;
    logic                              r_count_only;
    logic                              cfg_wr;
    logic [2:0]                        cfg_idx;

    logic        r_in_valid;
    t_in_beat    r_in;

    logic        r_line_open;
    logic        r_zero_seen;
    logic        r_line_found;
    logic [31:0] r_line_cnt;
    logic [31:0] r_match_cnt;
    logic        r_any;

    t_out_beat   r_q [2];
    logic [1:0]  r_q_cnt;
    t_out_beat   n_q [2];
    logic [1:0]  n_q_cnt;

    logic        pop;
    logic        room;
    logic        fire;
    logic        is_eos;
    logic        is_nl;
    logic        is_text;
    logic        end_line;
    logic        sel;
    logic        push_v;
    logic [31:0] lc_inc;
    logic [31:0] mc_inc;
    t_out_beat   verdict;
    t_out_beat   summary;
    t_win_ctl    win_ctl;
    logic        hit;
    logic        empty_pat;

    // config port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[5:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat         <= '0;
            r_pat_len     <= '0;
            r_ignore_case <= 1'b0;
            r_invert      <= 1'b0;
            r_count_only  <= 1'b0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                RegPat0:       r_pat[0]      <= pwdata;
                RegPat1:       r_pat[1]      <= pwdata;
                RegPat2:       r_pat[2]      <= pwdata;
                RegPat3:       r_pat[3]      <= pwdata;
                RegPatLen:     r_pat_len     <= pwdata[5:0];
                RegIgnoreCase: r_ignore_case <= pwdata[0];
                RegInvert:     r_invert      <= pwdata[0];
                RegCountOnly:  r_count_only  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            RegPat0:       prdata = r_pat[0];
            RegPat1:       prdata = r_pat[1];
            RegPat2:       prdata = r_pat[2];
            RegPat3:       prdata = r_pat[3];
            RegPatLen:     prdata = WordBits'(r_pat_len);
            RegIgnoreCase: prdata = WordBits'(r_ignore_case);
            RegInvert:     prdata = WordBits'(r_invert);
            RegCountOnly:  prdata = WordBits'(r_count_only);
            default:       prdata = '0;
        endcase
    end

    // input register
    assign pop        = o_out_valid && i_out_ready;
    assign room       = (r_q_cnt == 2'd0) || (r_q_cnt == 2'd1 && pop);
    assign fire       = r_in_valid && room;
    assign o_in_ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_beat;
        end
    end

    // decode and verdict
    assign is_eos   = r_in.end_of_stream;
    assign is_nl    = !is_eos && r_in.data_byte == CharNl;
    assign is_text  = !is_eos && !is_nl;
    assign end_line = is_nl || (is_eos && r_line_open);
    assign sel      = (empty_pat || r_line_found) ^ r_invert;
    assign lc_inc   = (r_line_cnt == Sat32) ? r_line_cnt : r_line_cnt + 32'd1;
    assign mc_inc   = (sel && r_match_cnt != Sat32) ? r_match_cnt + 32'd1 : r_match_cnt;
    assign push_v   = end_line && !r_count_only;

    assign win_ctl.shift = fire && is_text && !r_zero_seen && r_in.data_byte != 8'h00;
    assign win_ctl.clear = fire && (is_eos || is_nl);

    llm_window #(
        .MAX_PATTERN(MAX_PATTERN)
    ) u_window (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_pattern        (r_pat),
        .i_pattern_length (r_pat_len),
        .i_ignore_case    (r_ignore_case),
        .i_ctl            (win_ctl),
        .i_byte           (r_in.data_byte),
        .o_hit            (hit),
        .o_empty_pattern  (empty_pat)
    );

    always_comb begin
        verdict.result_kind    = KindLine;
        verdict.line_number    = lc_inc;
        verdict.selected       = sel;
        verdict.selected_count = '0;
        verdict.any_selected   = 1'b0;
        verdict.last           = !is_eos;

        summary.result_kind    = KindSummary;
        summary.line_number    = r_line_open ? lc_inc : r_line_cnt;
        summary.selected       = 1'b0;
        summary.selected_count = r_line_open ? mc_inc : r_match_cnt;
        summary.any_selected   = r_any || (r_line_open && sel);
        summary.last           = 1'b1;
    end

    // line and stream state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_open  <= 1'b0;
            r_zero_seen  <= 1'b0;
            r_line_found <= 1'b0;
            r_line_cnt   <= '0;
            r_match_cnt  <= '0;
            r_any        <= 1'b0;
        end else if (fire) begin
            if (is_eos) begin
                r_line_cnt  <= '0;
                r_match_cnt <= '0;
                r_any       <= 1'b0;
            end else if (is_nl) begin
                r_line_cnt  <= lc_inc;
                r_match_cnt <= mc_inc;
                r_any       <= r_any || sel;
            end
            if (is_eos || is_nl) begin
                r_line_open  <= 1'b0;
                r_zero_seen  <= 1'b0;
                r_line_found <= 1'b0;
            end else begin
                r_line_open <= 1'b1;
                if (!r_zero_seen && r_in.data_byte == 8'h00) begin
                    r_zero_seen <= 1'b1;
                end
                if (win_ctl.shift && hit) begin
                    r_line_found <= 1'b1;
                end
            end
        end
    end

    // output queue
    always_comb begin
        n_q[0]  = r_q[0];
        n_q[1]  = r_q[1];
        n_q_cnt = r_q_cnt;
        if (fire) begin
            if (push_v) begin
                n_q[0]  = verdict;
                n_q[1]  = summary;
                n_q_cnt = is_eos ? 2'd2 : 2'd1;
            end else if (is_eos) begin
                n_q[0]  = summary;
                n_q_cnt = 2'd1;
            end else begin
                n_q_cnt = 2'd0;
            end
        end else if (pop) begin
            n_q[0]  = r_q[1];
            n_q_cnt = r_q_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_cnt <= '0;
        end else begin
            r_q_cnt <= n_q_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q[0] <= n_q[0];
        r_q[1] <= n_q[1];
    end

    assign o_out_valid = (r_q_cnt != 2'd0);
    assign o_out_beat  = r_q[0];

endmodule

>>> hw/rtl/llm_window.sv
module llm_window
    import llm_pkg::*;
#(
    parameter int MAX_PATTERN = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [NumWords-1:0][WordBits-1:0] i_pattern,
    input  logic [5:0]                         i_pattern_length,
    input  logic                               i_ignore_case,
    input  t_win_ctl                           i_ctl,
    input  logic [7:0]                         i_byte,
    output logic                               o_hit,
    output logic                               o_empty_pattern
);

    localparam int LW = $clog2(MAX_PATTERN + 1);
    localparam int IW = $clog2(PatBytes);

    logic [PatBytes-1:0][7:0]    pat_bytes;
    logic [LW-1:0]               len_c;
    logic [LW-1:0]               eff_len;
    logic [MAX_PATTERN-1:0][7:0] pat_al;
    logic [MAX_PATTERN-1:0]      pat_mask;

    logic [LW-1:0]               r_eff_len;
    logic [MAX_PATTERN-1:0][7:0] r_pat_al;
    logic [MAX_PATTERN-1:0]      r_pat_mask;

    logic [MAX_PATTERN-1:0][7:0] r_win;
    logic [MAX_PATTERN-1:0][7:0] win_n;
    logic [LW-1:0]               r_cnt;
    logic [LW-1:0]               cnt_n;
    logic                        all_eq;

    assign pat_bytes = i_pattern;

    // effective length: clamp, then stop at the first zero byte
    always_comb begin
        len_c = (i_pattern_length > 6'(MAX_PATTERN)) ? LW'(MAX_PATTERN)
                                                       : LW'(i_pattern_length);
        eff_len = len_c;
        for (int k = MAX_PATTERN - 1; k >= 0; k--) begin
            if (LW'(k) < len_c && pat_bytes[k] == 8'h00) begin
                eff_len = LW'(k);
            end
        end
    end

    // pattern reversed so that its last byte lines up with the newest byte
    always_comb begin
        logic [IW-1:0] idx;
        idx = '0;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            pat_mask[i] = LW'(i) < eff_len;
            idx         = IW'(int'(eff_len) - i - 1);
            pat_al[i]   = fold(pat_bytes[idx], i_ignore_case);
        end
    end

    always_ff @(posedge i_clk) begin
        r_eff_len  <= eff_len;
        r_pat_al   <= pat_al;
        r_pat_mask <= pat_mask;
    end

    always_comb begin
        win_n[0] = i_byte;
        for (int i = 1; i < MAX_PATTERN; i++) begin
            win_n[i] = r_win[i-1];
        end
        cnt_n  = (r_cnt == LW'(MAX_PATTERN)) ? r_cnt : r_cnt + 1'b1;
        all_eq = 1'b1;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if (r_pat_mask[i] && fold(win_n[i], i_ignore_case) != r_pat_al[i]) begin
                all_eq = 1'b0;
            end
        end
    end

    assign o_hit           = (r_eff_len != '0) && (cnt_n >= r_eff_len) && all_eq;
    assign o_empty_pattern = (r_eff_len == '0);

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_win <= win_n;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctl.clear) begin
            r_cnt <= '0;
        end else if (i_ctl.shift) begin
            r_cnt <= cnt_n;
        end
    end

endmodule

>>> dv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import llm_pkg::*;

    localparam int TimeoutCycles = 300000;
    localparam int DrainCycles   = 8;
    localparam int ItemTarget    = 1250;
    localparam string Alphabet   = "aAbBc";

    logic                i_clk      = 1'b0;
    logic                i_rst_n    = 1'b0;
    logic                psel       = 1'b0;
    logic                penable    = 1'b0;
    logic                pwrite     = 1'b0;
    logic [AddrBits-1:0] paddr      = '0;
    logic [WordBits-1:0] pwdata     = '0;
    logic [WordBits-1:0] prdata;
    logic                pready;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    t_in_beat            i_in_beat  = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    t_out_beat           o_out_beat;

    literal_line_matcher u_top (.*);

    always #4 i_clk = ~i_clk;

    // shadow of the config registers
    logic [63:0] pat_words [NumWords] = '{default: '0};
    logic [5:0]  pat_len     = '0;
    logic        fold_case   = 1'b0;
    logic        invert_sel  = 1'b0;
    logic        counts_only = 1'b0;

    // line search state, tail[0] is the newest byte
    logic [7:0]  tail [PatBytes] = '{default: '0};
    int unsigned tail_fill      = 0;
    bit          line_open      = 1'b0;
    bit          nul_seen       = 1'b0;
    bit          hit            = 1'b0;
    logic [31:0] lines_seen     = '0;
    logic [31:0] lines_selected = '0;
    bit          any_hit        = 1'b0;

    t_out_beat   verdicts_due [$];

    bit stall_en          = 1'b1;
    int errors            = 0;
    int beats_sent        = 0;
    int lines_checked     = 0;
    int summaries_checked = 0;
    int cycles            = 0;

    function automatic logic [7:0] pat_at(int k);
        return pat_words[k / 8][8 * (k % 8) +: 8];
    endfunction

    function automatic logic [7:0] lower(logic [7:0] c);
        if (fold_case && c >= CharUpA && c <= CharUpZ) begin
            return c | 8'h20;
        end
        return c;
    endfunction

    function automatic int pat_span();
        int n;
        n = (pat_len > PatBytes) ? PatBytes : int'(pat_len);
        for (int k = 0; k < n; k++) begin
            if (pat_at(k) == 8'h00) begin
                return k;
            end
        end
        return n;
    endfunction

    function automatic bit tail_has_pattern(int n);
        if (n == 0 || tail_fill < n) begin
            return 1'b0;
        end
        for (int j = 0; j < n; j++) begin
            if (lower(pat_at(j)) != lower(tail[n - 1 - j])) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic void reset_line();
        foreach (tail[k]) tail[k] = 8'h00;
        tail_fill = 0;
        line_open = 1'b0;
        nul_seen  = 1'b0;
        hit       = 1'b0;
    endfunction

    function automatic void close_line(bit final_beat);
        bit        sel;
        t_out_beat r;
        sel = (pat_span() == 0 || hit) ^ invert_sel;
        if (lines_seen != '1) begin
            lines_seen++;
        end
        if (sel) begin
            if (lines_selected != '1) begin
                lines_selected++;
            end
            any_hit = 1'b1;
        end
        reset_line();
        if (!counts_only) begin
            r             = '0;
            r.result_kind = KindLine;
            r.line_number = lines_seen;
            r.selected    = sel;
            r.last        = final_beat;
            verdicts_due.push_back(r);
        end
    endfunction

    function automatic void predict_beat(t_in_beat b);
        t_out_beat r;
        if (b.end_of_stream) begin
            if (line_open) begin
                close_line(1'b0);
            end
            r                = '0;
            r.result_kind    = KindSummary;
            r.line_number    = lines_seen;
            r.selected_count = lines_selected;
            r.any_selected   = any_hit;
            r.last           = 1'b1;
            verdicts_due.push_back(r);
            lines_seen     = '0;
            lines_selected = '0;
            any_hit        = 1'b0;
            reset_line();
            return;
        end
        if (b.data_byte == CharNl) begin
            close_line(1'b1);
            return;
        end
        line_open = 1'b1;
        if (nul_seen) begin
            return;
        end
        if (b.data_byte == 8'h00) begin
            nul_seen = 1'b1;
            return;
        end
        for (int k = PatBytes - 1; k > 0; k--) begin
            tail[k] = tail[k - 1];
        end
        tail[0] = b.data_byte;
        if (tail_fill < PatBytes) begin
            tail_fill++;
        end
        if (tail_has_pattern(pat_span())) begin
            hit = 1'b1;
        end
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (verdicts_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected beat, expected none got %p", $time, o_out_beat);
            end else begin
                want = verdicts_due.pop_front();
                check_field("result_kind", want.result_kind, o_out_beat.result_kind);
                check_field("line_number", want.line_number, o_out_beat.line_number);
                check_field("selected", want.selected, o_out_beat.selected);
                check_field("selected_count", want.selected_count,
                            o_out_beat.selected_count);
                check_field("any_selected", want.any_selected, o_out_beat.any_selected);
                check_field("last", want.last, o_out_beat.last);
                if (want.result_kind == KindSummary) begin
                    summaries_checked++;
                end else begin
                    lines_checked++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        i_out_ready <= stall_en ? ($urandom_range(99) >= 33) : 1'b1;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > TimeoutCycles) begin
            $display("%0t: timeout, %0d results outstanding", $time, verdicts_due.size());
            $display("tb_top: errors");
            $finish;
        end
    end

    task automatic send_beat(logic [7:0] d, bit eos);
        t_in_beat b;
        b.data_byte     = d;
        b.end_of_stream = eos;
        if (stall_en && $urandom_range(99) < 33) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 33);
        end
        i_in_valid <= 1'b1;
        i_in_beat  <= b;
        predict_beat(b);
        beats_sent++;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic send_text(string s);
        foreach (s[i]) send_beat(s[i], 1'b0);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] v);
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            RegPat0, RegPat1, RegPat2, RegPat3: pat_words[idx[1:0]] = v;
            RegPatLen:     pat_len     = v[5:0];
            RegIgnoreCase: fold_case   = v[0];
            RegInvert:     invert_sel  = v[0];
            RegCountOnly:  counts_only = v[0];
            default: ;
        endcase
    endtask

    task automatic set_pattern(string s, logic [5:0] len);
        logic [63:0] w;
        int          idx;
        for (int i = 0; i < NumWords; i++) begin
            for (int k = 0; k < 8; k++) begin
                idx = 8 * i + k;
                w[8 * k +: 8] = (idx < s.len()) ? s[idx] : 8'h00;
            end
            write_reg(RegPat0 + 3'(i), w);
        end
        write_reg(RegPatLen, 64'(len));
    endtask

    task automatic test_empty_pattern();
        send_text("ab\n");
        send_text("\n");
        send_beat(8'hFF, 1'b1);
        send_beat(8'h00, 1'b1);
    endtask

    task automatic test_case_fold();
        set_pattern("Ab", 6'd2);
        send_text("xaB\n");
        send_text("zAbz\n");
        write_reg(RegIgnoreCase, 64'd1);
        send_text("xaB\n");
        set_pattern("@[", 6'd2);
        send_text("`{\n");
        send_text("@[\n");
        write_reg(RegIgnoreCase, 64'd0);
    endtask

    task automatic test_invert_count_only();
        set_pattern("q", 6'd1);
        write_reg(RegInvert, 64'd1);
        send_text("q\nr\n");
        write_reg(RegCountOnly, 64'd1);
        send_text("q\nr");
        send_beat(8'h5A, 1'b1);
        write_reg(RegCountOnly, 64'd0);
        send_text("rr");
        send_beat(8'h00, 1'b1);
        write_reg(RegInvert, 64'd0);
    endtask

    task automatic test_zero_bytes();
        set_pattern("ab", 6'd2);
        send_beat(8'h61, 1'b0);
        send_beat(8'h00, 1'b0);
        send_text("ab\n");
        // pattern cut short by its zero byte, length above the maximum
        write_reg(RegPat0, 64'h0000_0000_0000_6363);
        write_reg(RegPat1, '1);
        write_reg(RegPat2, '1);
        write_reg(RegPat3, '1);
        write_reg(RegPatLen, 64'd63);
        send_text("xcc\n");
        send_beat(8'hFF, 1'b0);
        send_text("c\n");
    endtask

    task automatic test_midline_config();
        set_pattern("ab", 6'd2);
        send_text("ab");
        write_reg(RegInvert, 64'd1);
        send_text("\n");
        send_text("a");
        set_pattern("", 6'd0);
        send_text("q");
        write_reg(RegInvert, 64'd0);
        send_text("\n");
        send_beat(8'h0A, 1'b1);
    endtask

    function automatic logic [7:0] text_char();
        int r;
        r = $urandom_range(99);
        if (r < 70) begin
            return Alphabet[$urandom_range(0, Alphabet.len() - 1)];
        end else if (r < 73) begin
            return 8'h00;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic random_config(int phase);
        logic [63:0] w;
        logic [7:0]  c;
        int          len;
        for (int i = 0; i < NumWords; i++) begin
            for (int k = 0; k < 8; k++) begin
                c = Alphabet[$urandom_range(0, Alphabet.len() - 1)];
                if (phase % 6 >= 3 && $urandom_range(9) == 0) begin
                    c = 8'($urandom_range(0, 255));
                end
                w[8 * k +: 8] = c;
            end
            write_reg(RegPat0 + 3'(i), w);
        end
        case (phase % 6)
            0:       len = 0;
            1:       len = 32;
            2:       len = 63;
            3:       len = $urandom_range(1, 8);
            4:       len = $urandom_range(1, 4);
            default: len = $urandom_range(0, 63);
        endcase
        write_reg(RegPatLen, 64'(len));
        write_reg(RegIgnoreCase, 64'($urandom_range(1)));
        write_reg(RegInvert, 64'($urandom_range(1)));
        write_reg(RegCountOnly, 64'($urandom_range(3) == 0));
    endtask

    task automatic random_line();
        logic [7:0] c;
        int         n;
        repeat ($urandom_range(0, 5)) send_beat(text_char(), 1'b0);
        if ($urandom_range(1)) begin
            n = pat_span();
            for (int k = 0; k < n; k++) begin
                c = pat_at(k);
                if ($urandom_range(1) && ((c | 8'h20) >= 8'h61) && ((c | 8'h20) <= 8'h7A)) begin
                    c = c ^ 8'h20;
                end
                send_beat(c, 1'b0);
            end
        end
        repeat ($urandom_range(0, 5)) send_beat(text_char(), 1'b0);
        if ($urandom_range(19) != 0) begin
            send_beat(CharNl, 1'b0);
        end
    endtask

    task automatic test_random_streams();
        int phase;
        phase = 0;
        while (beats_sent < ItemTarget) begin
            random_config(phase);
            stall_en = (phase % 5 != 2);
            repeat ($urandom_range(4, 12)) begin
                random_line();
                if ($urandom_range(15) == 0) begin
                    settle();
                end
            end
            if ($urandom_range(2) == 0) begin
                send_beat(8'($urandom_range(0, 255)), 1'b1);
            end
            phase++;
        end
        stall_en = 1'b1;
        send_beat(8'($urandom_range(0, 255)), 1'b1);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_pattern();
        test_case_fold();
        test_invert_count_only();
        test_zero_bytes();
        test_midline_config();
        test_random_streams();
        settle();
        $display("run covered %0d input beats, %0d line verdicts and %0d stream summaries",
                 beats_sent, lines_checked, summaries_checked);
        if (errors == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
